### rtl/core/mpc_pkg.sv
package mpc_pkg;

    // Default values of the top-level parameters.
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 20;

    // Fixed-point constants of the kinematics.
    localparam logic [30:0] DEG2RAD_Q32 = 31'd74961321;
    localparam logic [30:0] CORDIC_K_Q30 = 31'd652032874;
    localparam logic [30:0] RPM_PER_RADS_Q16 = 31'd625823;
    localparam logic [30:0] PI_DIVISOR = 31'd50;

    // Width of the divider: dividend magnitude bits and remainder bits.
    localparam int DIV_BITS = 50;
    localparam int DREM_W   = 37;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_WHEEL_RADIUS   = 3'd0;
    localparam logic [2:0] CFG_OFFSET_SUM     = 3'd1;
    localparam logic [2:0] CFG_CONTROL_PERIOD = 3'd2;
    localparam logic [2:0] CFG_APPROACH_SPEED = 3'd3;
    localparam logic [2:0] CFG_CRUISE_SPEED   = 3'd4;
    localparam logic [2:0] CFG_ARRIVAL_ZONE   = 3'd5;
    localparam logic [2:0] CFG_MAX_WHEEL_RPM  = 3'd6;

    // Operation codes of the shared arithmetic unit.
    localparam logic [1:0] OP_MUL    = 2'd0;
    localparam logic [1:0] OP_DIV    = 2'd1;
    localparam logic [1:0] OP_CORDIC = 2'd2;

    typedef struct packed {
        logic [15:0] wheel_radius;
        logic [16:0] wheel_offset_sum;
        logic [15:0] control_period;
        logic [15:0] approach_speed;
        logic [15:0] cruise_speed;
        logic [15:0] arrival_zone;
        logic [9:0]  max_wheel_rpm;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_alu_rsp;

    // Saturate a wide signed value to a range.
    function automatic logic signed [63:0] clamp64(logic signed [63:0] v,
                                                   logic signed [63:0] lo,
                                                   logic signed [63:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(logic signed [63:0] v);
        logic signed [63:0] c;
        c = clamp64(v, -64'sd2147483648, 64'sd2147483647);
        return c[31:0];
    endfunction

    function automatic logic signed [63:0] abs64(logic signed [63:0] v);
        return (v < 0) ? -v : v;
    endfunction

endpackage

### rtl/core/mpc_cfg.sv
module mpc_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [2:0]         i_index,
    input  logic [16:0]        i_data,
    output mpc_pkg::t_cfg      o_cfg
);
    import mpc_pkg::*;

    t_cfg r_cfg;

    // Register bank; writes to an unknown index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wheel_radius     <= 16'd1966;
            r_cfg.wheel_offset_sum <= 17'd15598;
            r_cfg.control_period   <= 16'd6554;
            r_cfg.approach_speed   <= 16'd2294;
            r_cfg.cruise_speed     <= 16'd5177;
            r_cfg.arrival_zone     <= 16'd655;
            r_cfg.max_wheel_rpm    <= 10'd100;
        end else if (i_we) begin
            unique case (i_index)
                CFG_WHEEL_RADIUS:   r_cfg.wheel_radius     <= i_data[15:0];
                CFG_OFFSET_SUM:     r_cfg.wheel_offset_sum <= i_data;
                CFG_CONTROL_PERIOD: r_cfg.control_period   <= i_data[15:0];
                CFG_APPROACH_SPEED: r_cfg.approach_speed   <= i_data[15:0];
                CFG_CRUISE_SPEED:   r_cfg.cruise_speed     <= i_data[15:0];
                CFG_ARRIVAL_ZONE:   r_cfg.arrival_zone     <= i_data[15:0];
                CFG_MAX_WHEEL_RPM:  r_cfg.max_wheel_rpm    <= i_data[9:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/mpc_alu.sv
module mpc_alu #(
    parameter int CORDIC_STEPS = mpc_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpc_pkg::t_alu_req i_req,
    output mpc_pkg::t_alu_rsp o_rsp
);
    import mpc_pkg::*;

    localparam int MAXN  = (DIV_BITS > CORDIC_STEPS) ? DIV_BITS : CORDIC_STEPS;
    localparam int CNT_W = $clog2(MAXN + 1);

    logic                     r_busy, n_busy;
    logic [1:0]               r_op, n_op;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_done, n_done;
    logic [63:0]              r_res, n_res;
    logic signed [63:0]       r_x, n_x, r_y, n_y;
    logic [DIV_BITS-1:0]      r_dq, n_dq;
    logic [DREM_W-1:0]        r_rem, n_rem, r_div, n_div;
    logic                     r_neg, n_neg;

    logic signed [66:0]       prod;
    logic signed [63:0]       mag;
    logic [DREM_W-1:0]        trial;
    logic                     ge;
    logic [DIV_BITS-1:0]      dq_step;
    logic [63:0]              quot;
    logic signed [63:0]       xs, ys;

    // Signed-by-unsigned multiply, registered at the output.
    assign prod = $signed(i_req.a[34:0]) * $signed({1'b0, i_req.b[30:0]});
    assign mag  = abs64($signed(i_req.a));

    // One restoring division step per cycle.
    assign trial   = {r_rem[DREM_W-2:0], r_dq[DIV_BITS-1]};
    assign ge      = (trial >= r_div);
    assign dq_step = {r_dq[DIV_BITS-2:0], ge};
    assign quot    = {{(64-DIV_BITS){1'b0}}, dq_step};

    // One CORDIC vectoring step per cycle.
    assign xs = r_x >>> r_cnt;
    assign ys = r_y >>> r_cnt;

    always_comb begin
        n_busy = r_busy;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_res  = r_res;
        n_x    = r_x;
        n_y    = r_y;
        n_dq   = r_dq;
        n_rem  = r_rem;
        n_div  = r_div;
        n_neg  = r_neg;
        if (!r_busy) begin
            if (i_req.start) begin
                n_op  = i_req.op;
                n_cnt = '0;
                unique case (i_req.op)
                    OP_MUL: begin
                        n_res  = prod[63:0];
                        n_done = 1'b1;
                    end
                    OP_DIV: begin
                        n_busy = 1'b1;
                        n_dq   = mag[DIV_BITS-1:0];
                        n_rem  = '0;
                        n_div  = {1'b0, i_req.b[DREM_W-2:0]};
                        n_neg  = i_req.a[63];
                    end
                    OP_CORDIC: begin
                        n_busy = 1'b1;
                        n_x    = $signed(i_req.a);
                        n_y    = $signed(i_req.b);
                    end
                    default: begin
                        n_res  = '0;
                        n_done = 1'b1;
                    end
                endcase
            end
        end else begin
            n_cnt = r_cnt + 1'b1;
            if (r_op == OP_DIV) begin
                n_dq  = dq_step;
                n_rem = ge ? (trial - r_div) : trial;
                if (r_cnt == CNT_W'(DIV_BITS - 1)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                    n_res  = r_neg ? (64'd0 - quot) : quot;
                end
            end else begin
                if (r_y > 0) begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                end else begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                end
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                    n_res  = n_x;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_x   <= n_x;
        r_y   <= n_y;
        r_dq  <= n_dq;
        r_rem <= n_rem;
        r_div <= n_div;
        r_neg <= n_neg;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

### rtl/core/mecanum_position_controller_core.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    four wheel angles, target x, y, heading
// output    out        o_out_valid / i_out_ready  four wheel speeds, odometry x, y, heading
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// The shared divider sets most of the time an item takes: up to eight divides of
// 50 steps each, plus a vectoring run of CORDIC_STEPS steps and the
// multiplies. Input is taken only while the sequencer is idle.
// The result sits in an output register, so the next beat is taken while it waits.
// Synchronous active-low reset clears the sequencer, the output valid flag and
// the heading integral, and loads the configuration registers with their defaults.
module mecanum_position_controller_core #(
    parameter int FRAC_BITS    = mpc_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = mpc_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_angle_front_right,
    input  logic signed [31:0] i_angle_front_left,
    input  logic signed [31:0] i_angle_rear_left,
    input  logic signed [31:0] i_angle_rear_right,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_heading,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [10:0] o_speed_front_right,
    output logic signed [10:0] o_speed_front_left,
    output logic signed [10:0] o_speed_rear_left,
    output logic signed [10:0] o_speed_rear_right,
    output logic signed [31:0] o_odom_x,
    output logic signed [31:0] o_odom_y,
    output logic signed [31:0] o_odom_heading,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);
    import mpc_pkg::*;

    localparam logic signed [63:0] PI_LIM   = 64'sd3 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] DEADBAND = 64'((2 ** FRAC_BITS + 100) / 200);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_OX1  = 5'd1;
    localparam logic [4:0] S_OX2  = 5'd2;
    localparam logic [4:0] S_OY1  = 5'd3;
    localparam logic [4:0] S_OY2  = 5'd4;
    localparam logic [4:0] S_OH1  = 5'd5;
    localparam logic [4:0] S_OH2  = 5'd6;
    localparam logic [4:0] S_OH3  = 5'd7;
    localparam logic [4:0] S_DX   = 5'd8;
    localparam logic [4:0] S_COR  = 5'd9;
    localparam logic [4:0] S_VX1  = 5'd10;
    localparam logic [4:0] S_VX2  = 5'd11;
    localparam logic [4:0] S_VX3  = 5'd12;
    localparam logic [4:0] S_VY1  = 5'd13;
    localparam logic [4:0] S_VY2  = 5'd14;
    localparam logic [4:0] S_VY3  = 5'd15;
    localparam logic [4:0] S_PI   = 5'd16;
    localparam logic [4:0] S_IK   = 5'd17;
    localparam logic [4:0] S_W    = 5'd18;
    localparam logic [4:0] S_RM   = 5'd19;
    localparam logic [4:0] S_RD   = 5'd20;
    localparam logic [4:0] S_DONE = 5'd21;

    // Speed level of one axis from its distance to the target.
    function automatic logic [15:0] axis_level(logic signed [63:0] d, logic [15:0] zone,
                                               logic [15:0] appr, logic [15:0] cruise);
        logic signed [63:0] ad;
        ad = abs64(d);
        if (ad <= $signed(64'(zone)))
            return 16'd0;
        else if (ad < $signed(64'(zone) * 64'd10))
            return appr;
        else
            return cruise;
    endfunction

    t_cfg     cfg;
    t_alu_req req;
    t_alu_rsp rsp;

    logic [4:0]         r_state, n_state;
    logic               r_wait, n_wait;
    logic [1:0]         r_wk, n_wk;
    logic signed [31:0] r_a0, r_a1, r_a2, r_a3, r_tx, r_ty, r_th;
    logic signed [31:0] n_a0, n_a1, n_a2, n_a3, n_tx, n_ty, n_th;
    logic signed [63:0] r_t, n_t, r_xc, n_xc;
    logic signed [31:0] r_ox, n_ox, r_oy, n_oy, r_oh, n_oh;
    logic signed [33:0] r_dx, n_dx, r_dy, n_dy;
    logic [15:0]        r_lx, n_lx, r_ly, n_ly;
    logic signed [31:0] r_vx, n_vx, r_vy, n_vy, r_ik, n_ik, r_u, n_u, r_w, n_w;
    logic signed [31:0] r_integ, n_integ;
    logic [10:0]        r_spd [4];
    logic [10:0]        n_spd [4];
    logic               r_ovalid, n_ovalid;
    logic [10:0]        r_o_spd [4];
    logic signed [31:0] r_o_ox, r_o_oy, r_o_oh;
    logic               load_out;

    logic [15:0]        rad_eff;
    logic [16:0]        len_eff;
    logic signed [63:0] sum_x, sum_y, sum_h, dx_c, dy_c, err, s_w, res, v, tmp, lim;

    mpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    mpc_alu #(.CORDIC_STEPS(CORDIC_STEPS)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // Zero radius and zero offset are used as one LSB.
    assign rad_eff = (cfg.wheel_radius == 16'd0) ? 16'd1 : cfg.wheel_radius;
    assign len_eff = (cfg.wheel_offset_sum == 17'd0) ? 17'd1 : cfg.wheel_offset_sum;

    // Forward kinematics sums, distances and heading error.
    assign sum_x = 64'(r_a0) + 64'(r_a1) + 64'(r_a2) + 64'(r_a3);
    assign sum_y = 64'(r_a0) - 64'(r_a1) + 64'(r_a2) - 64'(r_a3);
    assign sum_h = 64'(r_a0) - 64'(r_a1) - 64'(r_a2) + 64'(r_a3);
    assign dx_c  = 64'(r_tx) - 64'(r_ox);
    assign dy_c  = 64'(r_ty) - 64'(r_oy);
    assign err   = 64'(r_th) - 64'(r_oh);
    assign res   = $signed(rsp.res);
    assign lim   = $signed({54'd0, cfg.max_wheel_rpm});

    // Wheel sum for the wheel now being worked on.
    always_comb begin
        case (r_wk)
            2'd0:    s_w = 64'(r_vx) + 64'(r_vy) + 64'(r_w);
            2'd1:    s_w = 64'(r_vx) - 64'(r_vy) - 64'(r_w);
            2'd2:    s_w = 64'(r_vx) + 64'(r_vy) - 64'(r_w);
            default: s_w = 64'(r_vx) - 64'(r_vy) + 64'(r_w);
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Sequencer: each arithmetic step issues one request and waits for done.
    always_comb begin
        n_state  = r_state;
        n_wait   = r_wait;
        n_wk     = r_wk;
        n_a0     = r_a0;
        n_a1     = r_a1;
        n_a2     = r_a2;
        n_a3     = r_a3;
        n_tx     = r_tx;
        n_ty     = r_ty;
        n_th     = r_th;
        n_t      = r_t;
        n_xc     = r_xc;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_oh     = r_oh;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_lx     = r_lx;
        n_ly     = r_ly;
        n_vx     = r_vx;
        n_vy     = r_vy;
        n_ik     = r_ik;
        n_u      = r_u;
        n_w      = r_w;
        n_integ  = r_integ;
        n_spd    = r_spd;
        n_ovalid = r_ovalid & ~i_out_ready;
        load_out = 1'b0;
        v        = '0;
        tmp      = '0;
        req.start = 1'b0;
        req.op    = OP_MUL;
        req.a     = '0;
        req.b     = '0;

        if (r_state != S_IDLE && r_state != S_DONE && r_state != S_DX) begin
            req.start = ~r_wait;
            n_wait    = 1'b1;
            if (rsp.done)
                n_wait = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a0    = i_angle_front_right;
                    n_a1    = i_angle_front_left;
                    n_a2    = i_angle_rear_left;
                    n_a3    = i_angle_rear_right;
                    n_tx    = i_target_x;
                    n_ty    = i_target_y;
                    n_th    = i_target_heading;
                    n_state = S_OX1;
                end
            end
            S_OX1: begin
                req.a = sum_x;
                req.b = 64'(DEG2RAD_Q32);
                if (rsp.done) begin
                    n_t     = res >>> 32;
                    n_state = S_OX2;
                end
            end
            S_OX2: begin
                req.a = r_t;
                req.b = 64'(rad_eff);
                if (rsp.done) begin
                    n_ox    = sat32(res >>> (FRAC_BITS + 2));
                    n_state = S_OY1;
                end
            end
            S_OY1: begin
                req.a = sum_y;
                req.b = 64'(DEG2RAD_Q32);
                if (rsp.done) begin
                    n_t     = res >>> 32;
                    n_state = S_OY2;
                end
            end
            S_OY2: begin
                req.a = r_t;
                req.b = 64'(rad_eff);
                if (rsp.done) begin
                    n_oy    = sat32(res >>> (FRAC_BITS + 2));
                    n_state = S_OH1;
                end
            end
            S_OH1: begin
                req.a = sum_h;
                req.b = 64'(DEG2RAD_Q32);
                if (rsp.done) begin
                    n_t     = res >>> 32;
                    n_state = S_OH2;
                end
            end
            S_OH2: begin
                req.a = r_t;
                req.b = 64'(rad_eff);
                if (rsp.done) begin
                    n_t     = res;
                    n_state = S_OH3;
                end
            end
            S_OH3: begin
                req.op = OP_DIV;
                req.a  = r_t;
                req.b  = {45'd0, len_eff, 2'b00};
                if (rsp.done) begin
                    n_oh    = sat32(res);
                    n_state = S_DX;
                end
            end
            S_DX: begin
                // Axis levels; at target both speeds stay zero.
                n_dx = 34'(dx_c);
                n_dy = 34'(dy_c);
                n_lx = axis_level(dx_c, cfg.arrival_zone, cfg.approach_speed,
                                  cfg.cruise_speed);
                n_ly = axis_level(dy_c, cfg.arrival_zone, cfg.approach_speed,
                                  cfg.cruise_speed);
                n_vx = '0;
                n_vy = '0;
                if (n_lx == 16'd0 && n_ly == 16'd0)
                    n_state = S_PI;
                else
                    n_state = S_COR;
            end
            S_COR: begin
                req.op = OP_CORDIC;
                req.a  = abs64(64'(r_dx));
                req.b  = abs64(64'(r_dy));
                if (rsp.done) begin
                    n_xc    = res;
                    n_state = S_VX1;
                end
            end
            S_VX1: begin
                if (r_xc <= 0 || r_lx == 16'd0) begin
                    req.start = 1'b0;
                    n_wait    = 1'b0;
                    n_state   = S_VY1;
                end else begin
                    req.a = abs64(64'(r_dx));
                    req.b = 64'(r_lx);
                    if (rsp.done) begin
                        n_t     = res;
                        n_state = S_VX2;
                    end
                end
            end
            S_VX2: begin
                req.op = OP_DIV;
                req.a  = r_t;
                req.b  = r_xc;
                if (rsp.done) begin
                    n_t     = res;
                    n_state = S_VX3;
                end
            end
            S_VX3: begin
                req.a = r_t;
                req.b = 64'(CORDIC_K_Q30);
                if (rsp.done) begin
                    v       = res >>> 30;
                    n_vx    = (r_dx < 0) ? 32'(-v) : 32'(v);
                    n_state = S_VY1;
                end
            end
            S_VY1: begin
                if (r_xc <= 0 || r_ly == 16'd0) begin
                    req.start = 1'b0;
                    n_wait    = 1'b0;
                    n_state   = S_PI;
                end else begin
                    req.a = abs64(64'(r_dy));
                    req.b = 64'(r_ly);
                    if (rsp.done) begin
                        n_t     = res;
                        n_state = S_VY2;
                    end
                end
            end
            S_VY2: begin
                req.op = OP_DIV;
                req.a  = r_t;
                req.b  = r_xc;
                if (rsp.done) begin
                    n_t     = res;
                    n_state = S_VY3;
                end
            end
            S_VY3: begin
                req.a = r_t;
                req.b = 64'(CORDIC_K_Q30);
                if (rsp.done) begin
                    v       = res >>> 30;
                    n_vy    = (r_dy < 0) ? 32'(-v) : 32'(v);
                    n_state = S_PI;
                end
            end
            S_PI: begin
                // Integral term, clamped.
                req.a = err;
                req.b = 64'(cfg.control_period);
                if (rsp.done) begin
                    tmp     = (res >>> FRAC_BITS) + 64'(r_integ);
                    n_ik    = 32'(clamp64(tmp, -PI_LIM, PI_LIM));
                    n_state = S_IK;
                end
            end
            S_IK: begin
                // Proportional plus integral, clamped, with deadband.
                req.op = OP_DIV;
                req.a  = 64'(r_ik);
                req.b  = 64'(PI_DIVISOR);
                if (rsp.done) begin
                    tmp     = clamp64((err >>> 1) + res, -PI_LIM, PI_LIM);
                    n_u     = (abs64(err) < DEADBAND) ? 32'sd0 : 32'(tmp);
                    n_integ = r_ik;
                    n_state = S_W;
                end
            end
            S_W: begin
                req.a = 64'(r_u);
                req.b = 64'(len_eff);
                if (rsp.done) begin
                    tmp     = res >>> FRAC_BITS;
                    n_w     = 32'(tmp);
                    n_wk    = 2'd0;
                    n_state = S_RM;
                end
            end
            S_RM: begin
                req.a = s_w;
                req.b = 64'(RPM_PER_RADS_Q16);
                if (rsp.done) begin
                    n_t     = res;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                req.op = OP_DIV;
                req.a  = r_t;
                req.b  = {32'd0, rad_eff, 16'd0};
                if (rsp.done) begin
                    tmp        = clamp64(res, -lim, lim);
                    n_spd[r_wk] = tmp[10:0];
                    if (r_wk == 2'd3) begin
                        n_state = S_DONE;
                    end else begin
                        n_wk    = r_wk + 2'd1;
                        n_state = S_RM;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    load_out = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_wait  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_wk     <= 2'd0;
            r_integ  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_wk     <= n_wk;
            r_integ  <= n_integ;
            r_ovalid <= n_ovalid;
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge i_clk) begin
        r_a0  <= n_a0;
        r_a1  <= n_a1;
        r_a2  <= n_a2;
        r_a3  <= n_a3;
        r_tx  <= n_tx;
        r_ty  <= n_ty;
        r_th  <= n_th;
        r_t   <= n_t;
        r_xc  <= n_xc;
        r_ox  <= n_ox;
        r_oy  <= n_oy;
        r_oh  <= n_oh;
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_lx  <= n_lx;
        r_ly  <= n_ly;
        r_vx  <= n_vx;
        r_vy  <= n_vy;
        r_ik  <= n_ik;
        r_u   <= n_u;
        r_w   <= n_w;
        r_spd <= n_spd;
    end

    // Output register holds the result beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_spd <= r_spd;
            r_o_ox  <= r_ox;
            r_o_oy  <= r_oy;
            r_o_oh  <= r_oh;
        end
    end

    assign o_out_valid         = r_ovalid;
    assign o_speed_front_right = r_o_spd[0];
    assign o_speed_front_left  = r_o_spd[1];
    assign o_speed_rear_left   = r_o_spd[2];
    assign o_speed_rear_right  = r_o_spd[3];
    assign o_odom_x            = r_o_ox;
    assign o_odom_y            = r_o_oy;
    assign o_odom_heading      = r_o_oh;

endmodule
